>>> src/vfv_pkg.sv
package vfv_pkg;

  // one input beat
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic       removed;
    logic [1:0] cell_type;
    logic       cell_visible;
  } out_item_t;

  // operation codes
  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // cell type codes
  typedef enum logic [1:0] {
    CT_EMPTY = 2'd0,
    CT_STONE = 2'd1,
    CT_GRASS = 2'd2
  } cell_type_e;

  // face neighbour index
  typedef logic [2:0] nbr_idx_t;

  localparam nbr_idx_t NBR_X_LO = 3'd0;
  localparam nbr_idx_t NBR_X_HI = 3'd1;
  localparam nbr_idx_t NBR_Y_LO = 3'd2;
  localparam nbr_idx_t NBR_Y_HI = 3'd3;
  localparam nbr_idx_t NBR_Z_LO = 3'd4;
  localparam nbr_idx_t NBR_Z_HI = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     fill_en;
    logic     cap_read;
    logic     rm_hit;
    logic     rd_nbr;
    logic     wr_nbr;
    nbr_idx_t nbr_idx;
    logic     out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       fill_last;
    logic       out_free;
  } dp_status_t;

endpackage

>>> src/vfv_ctrl.sv
module vfv_ctrl
  import vfv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_NBR   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  nbr_idx_t   nbr_q, nbr_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    nbr_d   = nbr_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (in_op_i)
            OP_FILL:   state_d = S_FILL;
            OP_REMOVE: state_d = S_CHECK;
            OP_READ:   state_d = S_CHECK;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill_en = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        if (status_i.op == OP_READ) begin
          cmd_o.cap_read = 1'b1;
          state_d        = S_DONE;
        end else if (status_i.hit) begin
          cmd_o.rm_hit  = 1'b1;
          cmd_o.rd_nbr  = 1'b1;
          cmd_o.nbr_idx = NBR_X_LO;
          nbr_d         = NBR_X_LO;
          state_d       = S_NBR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_NBR: begin
        // mark the neighbour whose type just arrived, fetch the next one if any
        cmd_o.wr_nbr = 1'b1;
        if (nbr_q == NBR_Z_HI) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_nbr  = 1'b1;
          cmd_o.nbr_idx = nbr_q + 3'd1;
          nbr_d         = nbr_q + 3'd1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nbr_q   <= NBR_X_LO;
    end else begin
      state_q <= state_d;
      nbr_q   <= nbr_d;
    end
  end

endmodule

>>> src/vfv_datapath.sv
module vfv_datapath
  import vfv_pkg::*;
#(
  parameter int unsigned GRID_DEPTH  = 16,
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_HEIGHT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  logic       out_stall_i
);

  localparam int unsigned Plane = GRID_DEPTH * GRID_WIDTH;
  localparam int unsigned Cells = Plane * GRID_HEIGHT;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned XW    = $clog2(GRID_WIDTH);
  localparam int unsigned YW    = $clog2(GRID_HEIGHT);
  localparam int unsigned ZW    = $clog2(GRID_DEPTH);

  localparam logic [XW-1:0] XMax       = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] YMax       = YW'(GRID_HEIGHT - 1);
  localparam logic [ZW-1:0] ZMax       = ZW'(GRID_DEPTH - 1);
  localparam logic [AW-1:0] StepX      = AW'(GRID_DEPTH);
  localparam logic [AW-1:0] StepY      = AW'(Plane);
  localparam logic [AW-1:0] StepZ      = AW'(1);

  // cell store
  logic [1:0] type_mem [Cells];
  logic       vis_mem  [Cells];

  // accepted item
  logic [1:0]    op_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [ZW-1:0] z_q;
  logic [AW-1:0] a_q;
  logic          inside_q;
  logic          filled_q;

  // fill walk
  logic [XW-1:0] fx_q;
  logic [YW-1:0] fy_q;
  logic [ZW-1:0] fz_q;
  logic [AW-1:0] fa_q;
  logic          fill_edge;
  logic [1:0]    fill_type;

  // neighbour pipeline
  logic [AW-1:0] nbr_addr;
  logic          nbr_ok;
  logic [AW-1:0] nb_wa_q;
  logic          nb_ok_q;

  // memory ports
  logic [AW-1:0] rd_addr;
  logic [1:0]    type_rd_q;
  logic          vis_rd_q;
  logic          type_we;
  logic [AW-1:0] type_wa;
  logic [1:0]    type_wd;
  logic          vis_we;
  logic [AW-1:0] vis_wa;
  logic          vis_wd;

  // input decode
  logic          in_inside;
  logic          in_edge;
  logic          in_top;
  logic [AW-1:0] in_addr;

  out_item_t res_q;
  out_item_t out_q;
  logic      out_valid_q;

  assign in_inside = (32'(in_data_i.pos_x) < GRID_WIDTH)
                  && (32'(in_data_i.pos_y) < GRID_HEIGHT)
                  && (32'(in_data_i.pos_z) < GRID_DEPTH);
  assign in_top    = (32'(in_data_i.pos_y) == GRID_HEIGHT - 1);
  assign in_edge   = (in_data_i.pos_x == '0) || (32'(in_data_i.pos_x) == GRID_WIDTH - 1)
                  || (in_data_i.pos_y == '0) || in_top
                  || (in_data_i.pos_z == '0) || (32'(in_data_i.pos_z) == GRID_DEPTH - 1);
  assign in_addr   = AW'(32'(in_data_i.pos_y) * Plane
                       + 32'(in_data_i.pos_x) * GRID_DEPTH
                       + 32'(in_data_i.pos_z));

  // fill cell contents from the walk position
  assign fill_type = (fy_q == YMax) ? CT_GRASS : CT_STONE;
  assign fill_edge = (fx_q == '0) || (fx_q == XMax) || (fy_q == '0) || (fy_q == YMax)
                  || (fz_q == '0) || (fz_q == ZMax);

  // neighbour address and bounds
  always_comb begin
    nbr_addr = a_q;
    nbr_ok   = 1'b0;
    unique case (cmd_i.nbr_idx)
      NBR_X_LO: begin nbr_addr = a_q - StepX; nbr_ok = (x_q != '0);  end
      NBR_X_HI: begin nbr_addr = a_q + StepX; nbr_ok = (x_q != XMax); end
      NBR_Y_LO: begin nbr_addr = a_q - StepY; nbr_ok = (y_q != '0);  end
      NBR_Y_HI: begin nbr_addr = a_q + StepY; nbr_ok = (y_q != YMax); end
      NBR_Z_LO: begin nbr_addr = a_q - StepZ; nbr_ok = (z_q != '0);  end
      NBR_Z_HI: begin nbr_addr = a_q + StepZ; nbr_ok = (z_q != ZMax); end
      default: begin
        nbr_addr = a_q;
        nbr_ok   = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd_i.rd_nbr ? nbr_addr : in_addr;

  // write port selection
  always_comb begin
    type_we = cmd_i.fill_en || cmd_i.rm_hit;
    type_wa = cmd_i.fill_en ? fa_q : a_q;
    type_wd = cmd_i.fill_en ? fill_type : CT_EMPTY;
    vis_we  = 1'b0;
    vis_wa  = nb_wa_q;
    vis_wd  = 1'b1;
    priority if (cmd_i.fill_en) begin
      vis_we = 1'b1;
      vis_wa = fa_q;
      vis_wd = fill_edge;
    end else if (cmd_i.rm_hit) begin
      vis_we = 1'b1;
      vis_wa = a_q;
      vis_wd = 1'b0;
    end else if (cmd_i.wr_nbr && nb_ok_q && (type_rd_q != CT_EMPTY)) begin
      vis_we = 1'b1;
      vis_wa = nb_wa_q;
      vis_wd = 1'b1;
    end
  end

  // cell store ports, registered read
  always_ff @(posedge clk_i) begin
    if (type_we) begin
      type_mem[type_wa] <= type_wd;
    end
    type_rd_q <= type_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_q <= vis_mem[rd_addr];
  end

  // item fields and neighbour write address
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.op;
      x_q      <= XW'(in_data_i.pos_x);
      y_q      <= YW'(in_data_i.pos_y);
      z_q      <= ZW'(in_data_i.pos_z);
      a_q      <= in_addr;
      inside_q <= in_inside;
    end
    nb_wa_q <= nbr_addr;
  end

  // grid holds data once a fill has started; neighbour in-bounds flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      nb_ok_q  <= 1'b0;
    end else begin
      if (cmd_i.fill_en) begin
        filled_q <= 1'b1;
      end
      nb_ok_q <= cmd_i.rd_nbr && nbr_ok;
    end
  end

  // fill walk counters, z fastest
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fx_q <= '0;
      fy_q <= '0;
      fz_q <= '0;
      fa_q <= '0;
    end else if (cmd_i.fill_en) begin
      fa_q <= fa_q + AW'(1);
      if (fz_q == ZMax) begin
        fz_q <= '0;
        if (fx_q == XMax) begin
          fx_q <= '0;
          fy_q <= fy_q + YW'(1);
        end else begin
          fx_q <= fx_q + XW'(1);
        end
      end else begin
        fz_q <= fz_q + ZW'(1);
      end
    end
  end

  // result being built
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q.removed      <= 1'b0;
      res_q.cell_type    <= ((in_data_i.op == OP_FILL) && in_inside)
                            ? (in_top ? CT_GRASS : CT_STONE) : CT_EMPTY;
      res_q.cell_visible <= (in_data_i.op == OP_FILL) && in_inside && in_edge;
    end else if (cmd_i.cap_read) begin
      res_q.cell_type    <= (inside_q && filled_q) ? type_rd_q : CT_EMPTY;
      res_q.cell_visible <= inside_q && filled_q && vis_rd_q;
    end else if (cmd_i.rm_hit) begin
      res_q.removed <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status
  assign status_o.op        = op_q;
  assign status_o.hit       = (op_q == OP_REMOVE) && inside_q && filled_q
                           && (type_rd_q != CT_EMPTY);
  assign status_o.fill_last = (fx_q == XMax) && (fy_q == YMax) && (fz_q == ZMax);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

>>> src/voxel_face_visibility_grid_unit.sv
// Voxel grid with per-cell type and face visibility mark.
// Input channel: in_valid_i / in_stall_o carry one in_item_t beat (op, x, y, z).
// Output channel: out_valid_o / out_stall_i carry one out_item_t beat per input.
// A beat is taken at a clock edge with valid high and stall low.
// Steps per item, from acceptance to the edge that registers the result:
//   read, or a remove of an empty or outside cell: center check, then the result
//   op code three: goes straight to the result
//   remove of a filled cell: center check, then one neighbour type read
//   per cycle through the single read port of the cell store
//   fill: every cell of the grid written in turn, one cell written per cycle
// The next item is accepted the cycle after the result is registered, one
// item in work at a time; a result waiting in the output register does not
// block acceptance of the next item, only the loading of its result.
// While out_stall_i is high the output beat holds; the block parks a finished
// result internally until the output register frees up.
// Reset (rst_ni low, asynchronous) clears the control state. The grid then
// reads as all empty and invisible until the first fill, which writes every
// cell; no clearing pass is needed.
module voxel_face_visibility_grid_unit
  import vfv_pkg::*;
#(
  parameter int unsigned GRID_DEPTH  = 16,
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_HEIGHT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  vfv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // cell store, address logic and result registers
  vfv_datapath #(
    .GRID_DEPTH  (GRID_DEPTH),
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // a result only loads into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a held output beat");

  // one item at a time: stall rises right after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in work");

  // fill writes never collide with remove writes
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.fill_en && (cmd.rm_hit || cmd.wr_nbr)))
    else $error("fill and remove write in the same cycle");

  // a loaded result shows up as valid in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule
